>>> hw/rtl/scrf_pkg.sv
`timescale 1ns / 1ps
package scrf_pkg;

  localparam int unsigned DefNumWords = 1024;
  localparam int unsigned IdxW        = 10;
  localparam int unsigned DataW       = 32;
  localparam int unsigned ResetIdxW   = 12;

  localparam logic [IdxW-1:0] IdxLock   = 10'h001;
  localparam logic [IdxW-1:0] IdxUnlock = 10'h002;
  localparam logic [IdxW-1:0] IdxCpuRst = 10'h091;

  localparam logic [DataW-1:0] LockKey   = 32'h0000_767B;
  localparam logic [DataW-1:0] UnlockKey = 32'h0000_DF0D;

  localparam logic       OpRead  = 1'b0;
  localparam logic       OpWrite = 1'b1;

  localparam logic [1:0] ActNone    = 2'd0;
  localparam logic [1:0] ActStop    = 2'd1;
  localparam logic [1:0] ActRelease = 2'd2;

  // Reserved bits that a write drops.
  function automatic logic [DataW-1:0] reserved_mask(input logic [IdxW-1:0] idx);
    logic [DataW-1:0] m;
    m = '0;
    unique case (idx)
      10'h040, 10'h042:                   m = 32'hFFF8_0FE4;
      10'h048:                            m = 32'hE0FF_C0CF;
      10'h04A:                            m = 32'hFC0F_C0FE;
      10'h058:                            m = 32'hFF80_FF80;
      10'h05E, 10'h062, 10'h066, 10'h06A: m = 32'hFFFF_0000;
      default:                            m = '0;
    endcase
    return m;
  endfunction

  // Value a word takes after reset.
  function automatic logic [DataW-1:0] reset_value(input logic [ResetIdxW-1:0] i);
    logic [DataW-1:0] v;
    v = '0;
    if (i == 12'h003) v = 32'h0000_0001;
    else if (i >= 12'h040 && i <= 12'h042) v = 32'h0002_8008;
    else if (i == 12'h043) v = 32'h0000_003F;
    else if (i >= 12'h044 && i <= 12'h046) v = 32'h0017_7EA0;
    else if (i == 12'h048) v = 32'h1F00_0200;
    else if (i == 12'h049) v = 32'h1840_0003;
    else if (i == 12'h04A) v = 32'h01E0_3201;
    else if (i == 12'h04B) v = 32'h01FF_CCCD;
    else if (i == 12'h04C || i == 12'h04D) v = 32'h0010_1941;
    else if (i == 12'h04E || i == 12'h04F) v = 32'h0000_0001;
    else if (i == 12'h050 || i == 12'h051) v = 32'h0000_3C01;
    else if (i == 12'h052) v = 32'h0000_3C21;
    else if (i == 12'h053) v = 32'h0000_2821;
    else if (i == 12'h054) v = 32'h0000_1E03;
    else if (i == 12'h055 || i == 12'h056) v = 32'h0000_2821;
    else if (i == 12'h057) v = 32'h0050_1903;
    else if (i == 12'h059) v = 32'h0000_0F03;
    else if (i == 12'h05A) v = 32'h0000_0F01;
    else if (i == 12'h05C || i == 12'h060 || i == 12'h064 || i == 12'h068)
      v = 32'h0010_1800;
    else if (i == 12'h05F || i == 12'h063 || i == 12'h067 || i == 12'h06B)
      v = 32'h0001_0000;
    else if (i == 12'h071) v = 32'h0000_0001;
    else if (i == 12'h090) v = 32'h01FF_3F0F;
    else if (i == 12'h096) v = 32'h0040_0000;
    else if (i == 12'h1C0 || i == 12'h1C1) v = 32'h0000_1601;
    else if (i >= 12'h1C2 && i <= 12'h1C8) v = 32'h0000_0601;
    else if (i >= 12'h1C9 && i <= 12'h1F5) v = 32'h0000_1601;
    else if (i == 12'h203) v = 32'hFFFF_FFFF;
    else if (i == 12'h204) v = 32'h003F_FFFF;
    else if (i == 12'h287) v = 32'h0001_0101;
    else if (i >= 12'h2D0 && i <= 12'h2D6) v = 32'h0000_0800;
    else if (i == 12'h2DC) v = 32'h0000_0020;
    return v;
  endfunction

endpackage

>>> hw/rtl/system_control_register_file_top.sv
// A word accepted goes into the input register, and its result moves on to the result
// register once that is empty or not stalled. Throughput: one word per cycle while the
// output is not stalled; the store has one read and one write port, is read at accept
// and is written when the word moves on to the result register, with a bypass for
// back-to-back words to one index. Reset: protection is set, and a pass loads the
// reset table into the store, one word a cycle, while no input word is accepted.
`timescale 1ns / 1ps
module system_control_register_file_top import scrf_pkg::*; #(
  parameter int unsigned NUM_WORDS = DefNumWords
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             operation_i,
  input  logic [IdxW-1:0]  word_index_i,
  input  logic [DataW-1:0] write_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [DataW-1:0] read_data_o,
  output logic             write_refused_o,
  output logic [1:0]       cpu1_action_o
);

  localparam int unsigned AW = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned XW = ((AW > IdxW) ? AW : IdxW) + 1;

  logic [DataW-1:0] mem [NUM_WORDS];

  logic          clearing_q;
  logic [AW-1:0] clr_q;
  logic          wp_q;

  logic             s1_valid_q;
  logic             s1_op_q;
  logic [IdxW-1:0]  s1_idx_q;
  logic [DataW-1:0] s1_data_q;
  logic             s1_inside_q;
  logic [DataW-1:0] s1_rd_q;
  logic             fwd_q;
  logic [DataW-1:0] fwd_data_q;

  logic             out_valid_q;
  logic [DataW-1:0] out_rd_q;
  logic             out_ref_q;
  logic [1:0]       out_act_q;

  logic [XW-1:0]    idx_x;
  logic [XW-1:0]    s1_idx_x;
  logic             in_inside;
  logic             accept;
  logic             s1_adv;

  logic             wp_d;
  logic             is_wr;
  logic             refused;
  logic             store_en;
  logic [DataW-1:0] data_m;
  logic [DataW-1:0] cur;
  logic [DataW-1:0] rd_res;
  logic [1:0]       act;

  assign idx_x     = XW'(word_index_i);
  assign s1_idx_x  = XW'(s1_idx_q);
  assign in_inside = idx_x < XW'(NUM_WORDS);
  assign s1_adv    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clearing_q || (s1_valid_q && !s1_adv);
  assign accept    = in_valid_i && !in_stall_o;

  // Result logic for the word in the input register.
  always_comb begin
    cur    = fwd_q ? fwd_data_q : s1_rd_q;
    is_wr  = (s1_op_q == OpWrite);
    wp_d   = wp_q;
    data_m = s1_data_q;
    if (is_wr && s1_idx_q == IdxLock && s1_data_q == LockKey) wp_d = 1'b1;
    if (is_wr && s1_idx_q == IdxUnlock) begin
      if (s1_data_q == UnlockKey) wp_d = 1'b0;
      data_m = '0;
    end
    data_m   = data_m & ~reserved_mask(s1_idx_q);
    refused  = is_wr && (s1_idx_q != IdxLock) && wp_d;
    store_en = is_wr && (s1_idx_q != IdxLock) && !wp_d && s1_inside_q;
    act      = ActNone;
    if (store_en && s1_idx_q == IdxCpuRst) begin
      if (data_m[1] && data_m[5]) act = ActStop;
      else if (!cur[1] && cur[5] && !data_m[5]) act = ActRelease;
    end
    rd_res = (!is_wr && s1_inside_q) ? cur : '0;
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem[clr_q] <= reset_value(ResetIdxW'(clr_q));
    end else if (s1_adv && store_en) begin
      mem[s1_idx_x[AW-1:0]] <= data_m;
    end
    if (accept) begin
      s1_rd_q <= mem[idx_x[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q  <= 1'b1;
      clr_q       <= '0;
      wp_q        <= 1'b1;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (clearing_q) begin
        if (clr_q == AW'(NUM_WORDS - 1)) clearing_q <= 1'b0;
        clr_q <= clr_q + 1'b1;
      end
      if (s1_adv) wp_q <= wp_d;
      if (accept) s1_valid_q <= 1'b1;
      else if (s1_adv) s1_valid_q <= 1'b0;
      if (s1_adv) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q     <= operation_i;
      s1_idx_q    <= word_index_i;
      s1_data_q   <= write_data_i;
      s1_inside_q <= in_inside;
      // The store read at this edge misses the write made at the same edge.
      fwd_q       <= s1_adv && store_en && (s1_idx_q == word_index_i);
      fwd_data_q  <= data_m;
    end
    if (s1_adv) begin
      out_rd_q  <= rd_res;
      out_ref_q <= refused;
      out_act_q <= act;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = out_rd_q;
  assign write_refused_o = out_ref_q;
  assign cpu1_action_o   = out_act_q;

endmodule

>>> hw/rtl/scrf_checker.sv
`timescale 1ns / 1ps
module scrf_checker import scrf_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [DataW-1:0] read_data_o,
  input logic             write_refused_o,
  input logic [1:0]       cpu1_action_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o))
    else $error("result word changed while stalled");

  a_ref_noact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_refused_o |-> cpu1_action_o == ActNone)
    else $error("refused write reported a core action");

  a_ref_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && write_refused_o |-> read_data_o == '0)
    else $error("refused write returned read data");

  a_act_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cpu1_action_o != ActNone |-> read_data_o == '0)
    else $error("core action on a word with read data");

  a_act_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cpu1_action_o != 2'd3)
    else $error("invalid core action code");

endmodule

bind system_control_register_file_top scrf_checker u_scrf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .read_data_o    (read_data_o),
  .write_refused_o(write_refused_o),
  .cpu1_action_o  (cpu1_action_o)
);
